[hw/rtl/hcfda_pkg.sv]
`default_nettype none

package hcfda_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned SUM_W      = 27;
  localparam int unsigned ACC_W      = 28;
  localparam int unsigned PIX_CNT_W  = 17;
  localparam int unsigned PAIR_CNT_W = 11;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic {
    REG_PIXEL_COUNT = 1'b0,
    REG_PAIR_COUNT  = 1'b1
  } reg_idx_t;

  localparam logic [PIX_CNT_W-1:0]  PIX_CNT_RST  = 17'h10000;
  localparam logic [PAIR_CNT_W-1:0] PAIR_CNT_RST = 11'd1;

endpackage

`default_nettype wire

[hw/rtl/hcfda_ram.sv]
`default_nettype none

module hcfda_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/hot_cold_frame_difference_accumulator.sv]
// Accumulates hot minus cold per pixel over pair_count frame pairs of a raster
// pixel stream (even frames hot, odd frames cold), one pixel per clock cycle
// while the output queue has room. Each pixel does one read-modify-write of
// its 28-bit sum in a single-port-write memory with registered read: the read
// is issued when the pixel is accepted and the updated sum is written back in
// the next cycle, with a bypass register covering back-to-back hits on the same
// entry. Results leave via the update stage and queue, only in the final cold
// frame, out_last_pixel marking the image's last pixel; a three-entry output
// queue lets the stream keep going while a result waits. Any register write
// restarts the run at pixel 0 of a hot frame; write registers only while idle.
// pixel_count of 0 acts as 1 and above MAX_PIXELS as MAX_PIXELS; pair_count of
// 0 acts as 1 and above MAX_PAIRS as MAX_PAIRS. The store needs no clearing.
`default_nettype none

module hot_cold_frame_difference_accumulator #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned MAX_PAIRS  = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [hcfda_pkg::PIX_W-1:0]       in_pixel_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [hcfda_pkg::SUM_W-1:0]     out_pixel_sum,
  output logic                                   out_last_pixel,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hcfda_pkg::APB_AW-1:0]      paddr,
  input  wire logic [hcfda_pkg::APB_DW-1:0]      pwdata,
  output logic      [hcfda_pkg::APB_DW-1:0]      prdata,
  output logic                                   pready
);

  localparam int unsigned AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned PXL = $clog2(MAX_PIXELS + 1);
  localparam int unsigned EW  = (PXL > hcfda_pkg::PIX_CNT_W) ? PXL : hcfda_pkg::PIX_CNT_W;
  localparam int unsigned PRL = $clog2(MAX_PAIRS + 1);
  localparam int unsigned PW  = (PRL > hcfda_pkg::PAIR_CNT_W) ? PRL : hcfda_pkg::PAIR_CNT_W;
  localparam int unsigned FW  = (MAX_PAIRS > 1) ? $clog2(2 * MAX_PAIRS) : 1;
  localparam int unsigned QD  = 3;

  typedef struct packed {
    logic                             last;
    logic [hcfda_pkg::SUM_W-1:0]      sum;
  } res_t;

  // configuration
  logic [hcfda_pkg::PIX_CNT_W-1:0]  pix_cnt_r;
  logic [hcfda_pkg::PAIR_CNT_W-1:0] pair_cnt_r;
  logic                             cfg_wr;
  hcfda_pkg::reg_idx_t              cfg_idx;

  // run position
  logic [AW-1:0] pix_idx_r, pix_idx_nxt;
  logic [FW-1:0] frm_idx_r, frm_idx_nxt;
  logic [EW-1:0] eff_pix;
  logic [PW-1:0] eff_pair;
  logic [PW:0]   frames_m1;
  logic          in_xfer;
  logic          cur_last;
  logic          cur_emit;

  // update stage
  logic                        s1_valid_r;
  logic                        s1_first_r;
  logic                        s1_sub_r;
  logic                        s1_emit_r;
  logic                        s1_last_r;
  logic [AW-1:0]               s1_addr_r;
  logic [hcfda_pkg::PIX_W-1:0] s1_val_r;
  logic [hcfda_pkg::ACC_W-1:0] rd_data;
  logic [hcfda_pkg::ACC_W-1:0] acc_base;
  logic [hcfda_pkg::ACC_W-1:0] acc_new;
  logic [hcfda_pkg::ACC_W-1:0] val_ext;

  // bypass of the most recent write
  logic                        fwd_valid_r;
  logic [AW-1:0]               fwd_addr_r;
  logic [hcfda_pkg::ACC_W-1:0] fwd_data_r;

  // result queue
  res_t       q_mem_r [QD];
  logic [1:0] q_rd_r;
  logic [1:0] q_wr_r;
  logic [1:0] q_cnt_r;
  logic       q_push;
  logic       q_pop;
  res_t       q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = hcfda_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      hcfda_pkg::REG_PIXEL_COUNT:
        prdata = hcfda_pkg::APB_DW'(pix_cnt_r);
      hcfda_pkg::REG_PAIR_COUNT:
        prdata = hcfda_pkg::APB_DW'(pair_cnt_r);
      default:
        prdata = '0;
    endcase
  end

  always_comb begin
    if (pix_cnt_r == '0) begin
      eff_pix = EW'(1);
    end else if (EW'(pix_cnt_r) > EW'(MAX_PIXELS)) begin
      eff_pix = EW'(MAX_PIXELS);
    end else begin
      eff_pix = EW'(pix_cnt_r);
    end
    if (pair_cnt_r == '0) begin
      eff_pair = PW'(1);
    end else if (PW'(pair_cnt_r) > PW'(MAX_PAIRS)) begin
      eff_pair = PW'(MAX_PAIRS);
    end else begin
      eff_pair = PW'(pair_cnt_r);
    end
  end

  assign frames_m1 = {eff_pair, 1'b0} - (PW + 1)'(1);
  assign in_ready  = ({1'b0, q_cnt_r} + {2'b00, s1_valid_r & s1_emit_r}) < 3'(QD);
  assign in_xfer   = in_valid & in_ready;
  assign cur_last  = (EW'(pix_idx_r) == (eff_pix - EW'(1)));
  assign cur_emit  = ((PW + 1)'(frm_idx_r) == frames_m1);

  always_comb begin
    pix_idx_nxt = pix_idx_r;
    frm_idx_nxt = frm_idx_r;
    if (in_xfer) begin
      if (cur_last) begin
        pix_idx_nxt = '0;
        frm_idx_nxt = cur_emit ? '0 : frm_idx_r + FW'(1);
      end else begin
        pix_idx_nxt = pix_idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r  <= hcfda_pkg::PIX_CNT_RST;
      pair_cnt_r <= hcfda_pkg::PAIR_CNT_RST;
      pix_idx_r  <= '0;
      frm_idx_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hcfda_pkg::REG_PIXEL_COUNT:
          pix_cnt_r <= pwdata[hcfda_pkg::PIX_CNT_W-1:0];
        hcfda_pkg::REG_PAIR_COUNT:
          pair_cnt_r <= pwdata[hcfda_pkg::PAIR_CNT_W-1:0];
        default: begin
        end
      endcase
      pix_idx_r <= '0;
      frm_idx_r <= '0;
    end else begin
      pix_idx_r <= pix_idx_nxt;
      frm_idx_r <= frm_idx_nxt;
    end
  end

  hcfda_ram #(
    .WIDTH (hcfda_pkg::ACC_W),
    .DEPTH (MAX_PIXELS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (acc_new),
    .raddr (pix_idx_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
    if (in_xfer) begin
      s1_first_r <= (frm_idx_r == '0);
      s1_sub_r   <= frm_idx_r[0];
      s1_emit_r  <= cur_emit;
      s1_last_r  <= cur_last;
      s1_addr_r  <= pix_idx_r;
      s1_val_r   <= in_pixel_value;
    end
  end

  assign val_ext = hcfda_pkg::ACC_W'(s1_val_r);

  always_comb begin
    if (s1_first_r) begin
      acc_base = '0;
    end else if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      acc_base = fwd_data_r;
    end else begin
      acc_base = rd_data;
    end
    acc_new = s1_sub_r ? acc_base - val_ext : acc_base + val_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= s1_valid_r;
    end
    if (s1_valid_r) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= acc_new;
    end
  end

  assign q_push = s1_valid_r & s1_emit_r;
  assign q_head = q_mem_r[q_rd_r];
  assign q_pop  = out_valid & out_ready;

  assign out_valid      = (q_cnt_r != '0);
  assign out_pixel_sum  = q_head.sum;
  assign out_last_pixel = q_head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_rd_r  <= '0;
      q_wr_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wr_r <= (q_wr_r == 2'(QD - 1)) ? '0 : q_wr_r + 2'd1;
      end
      if (q_pop) begin
        q_rd_r <= (q_rd_r == 2'(QD - 1)) ? '0 : q_rd_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + {1'b0, q_push} - {1'b0, q_pop};
    end
    if (q_push) begin
      q_mem_r[q_wr_r] <= '{last: s1_last_r, sum: acc_new[hcfda_pkg::SUM_W-1:0]};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hcfda_chk.sv]
`default_nettype none

module hcfda_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [hcfda_pkg::SUM_W-1:0]   out_pixel_sum,
  input wire logic                          out_last_pixel
);

  // a stalled result keeps its place
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_sum) && $stable(out_last_pixel))
    else $error("stalled result changed");

  // reset leaves an empty block that takes input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

  // a new result only appears after an earlier input transfer
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an input transfer");

endmodule

bind hot_cold_frame_difference_accumulator hcfda_chk u_hcfda_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pixel_sum  (out_pixel_sum),
  .out_last_pixel (out_last_pixel)
);

`default_nettype wire

[sim/tb_hot_cold_frame_difference_accumulator.sv]
`default_nettype none

module tb_hot_cold_frame_difference_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PIXELS   = 65536;
  localparam int unsigned MAX_PAIRS    = 1024;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned SETTLE       = 10;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef enum {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_mode_t;

  typedef struct {
    logic signed [hcfda_pkg::SUM_W-1:0] pix_sum;
    logic                               is_last;
  } pixel_result_t;

  class pixel_sum_tracker;
    bit [hcfda_pkg::ACC_W-1:0] acc_mem [MAX_PIXELS];
    int unsigned     pix_idx  = 0;
    int unsigned     frm_idx  = 0;
    int unsigned     pix_cnt  = hcfda_pkg::PIX_CNT_RST;
    int unsigned     pair_cnt = hcfda_pkg::PAIR_CNT_RST;
    pixel_result_t   pending_sums[$];
    int unsigned     mismatches = 0;

    static function int unsigned bounded(int unsigned v, int unsigned top);
      return (v == 0) ? 1 : ((v > top) ? top : v);
    endfunction

    function void report_mismatch(string msg);
      if (mismatches < 10) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    // any register write restarts the run
    function void set_register(hcfda_pkg::reg_idx_t r, logic [hcfda_pkg::APB_DW-1:0] d);
      case (r)
        hcfda_pkg::REG_PIXEL_COUNT: pix_cnt = 32'(d[hcfda_pkg::PIX_CNT_W-1:0]);
        hcfda_pkg::REG_PAIR_COUNT:  pair_cnt = 32'(d[hcfda_pkg::PAIR_CNT_W-1:0]);
        default: begin
        end
      endcase
      pix_idx = 0;
      frm_idx = 0;
    endfunction

    function void take_pixel(logic [hcfda_pkg::PIX_W-1:0] v);
      int unsigned   pixels;
      int unsigned   frames;
      int unsigned   idx;
      bit [hcfda_pkg::ACC_W-1:0] acc;
      pixel_result_t r;
      pixels = bounded(pix_cnt, MAX_PIXELS);
      frames = 2 * bounded(pair_cnt, MAX_PAIRS);
      idx = (pix_idx >= pixels) ? 0 : pix_idx;
      if (frm_idx >= frames) frm_idx = 0;
      if (frm_idx == 0) begin
        acc = hcfda_pkg::ACC_W'(v);
      end else if (frm_idx % 2 == 0) begin
        acc = acc_mem[idx] + v;
      end else begin
        acc = acc_mem[idx] - v;
      end
      acc_mem[idx] = acc;
      if (frm_idx == frames - 1) begin
        r.pix_sum = acc[hcfda_pkg::SUM_W-1:0];
        r.is_last = (idx == pixels - 1);
        pending_sums.push_back(r);
      end
      idx++;
      if (idx >= pixels) begin
        idx = 0;
        frm_idx++;
        if (frm_idx >= frames) frm_idx = 0;
      end
      pix_idx = idx;
    endfunction

    function void check_result(logic signed [hcfda_pkg::SUM_W-1:0] s, logic l);
      pixel_result_t want;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result sum %0d last %0b", s, l));
        return;
      end
      want = pending_sums.pop_front();
      if (s !== want.pix_sum)
        report_mismatch($sformatf("pixel_sum expected %0d got %0d", want.pix_sum, s));
      if (l !== want.is_last)
        report_mismatch($sformatf("last_pixel expected %0b got %0b", want.is_last, l));
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [hcfda_pkg::PIX_W-1:0]        in_pixel_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [hcfda_pkg::SUM_W-1:0] out_pixel_sum;
  logic                               out_last_pixel;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [hcfda_pkg::APB_AW-1:0]       paddr = '0;
  logic [hcfda_pkg::APB_DW-1:0]       pwdata = '0;
  logic [hcfda_pkg::APB_DW-1:0]       prdata;
  logic                               pready;

  pixel_sum_tracker tracker = new;
  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  longint unsigned  cycles = 0;

  hot_cold_frame_difference_accumulator #(
    .MAX_PIXELS(MAX_PIXELS),
    .MAX_PAIRS (MAX_PAIRS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_value(in_pixel_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_sum (out_pixel_sum),
    .out_last_pixel(out_last_pixel),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_pixel(in_pixel_value);
      if (out_valid && out_ready) tracker.check_result(out_pixel_sum, out_last_pixel);
    end
  end

  function automatic logic [hcfda_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return hcfda_pkg::PIX_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic apply_flow(input flow_mode_t m);
    case (m)
      FLOW_FREE:       begin idle_pct = 0;  stall_pct = 0;  end
      FLOW_SEND_IDLE:  begin idle_pct = 75; stall_pct = 0;  end
      FLOW_RECV_STALL: begin idle_pct = 0;  stall_pct = 75; end
      FLOW_BOTH:       begin idle_pct = 8;  stall_pct = 8;  end
      default:         begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic send_pixel(input logic [hcfda_pkg::PIX_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input hcfda_pkg::reg_idx_t r,
                           input logic [hcfda_pkg::APB_DW-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_register(r, d);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input hcfda_pkg::reg_idx_t r,
                                input logic [hcfda_pkg::APB_DW-1:0] want);
    logic [hcfda_pkg::APB_DW-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd !== want)
      tracker.report_mismatch($sformatf("register %s read %0h expected %0h", r.name(), rd, want));
  endtask

  task automatic start_run(input int unsigned pix, input int unsigned pairs);
    drain();
    apb_write(hcfda_pkg::REG_PIXEL_COUNT, hcfda_pkg::APB_DW'(pix));
    apb_write(hcfda_pkg::REG_PAIR_COUNT, hcfda_pkg::APB_DW'(pairs));
    check_register(hcfda_pkg::REG_PIXEL_COUNT,
                   hcfda_pkg::APB_DW'(pix[hcfda_pkg::PIX_CNT_W-1:0]));
    check_register(hcfda_pkg::REG_PAIR_COUNT,
                   hcfda_pkg::APB_DW'(pairs[hcfda_pkg::PAIR_CNT_W-1:0]));
  endtask

  initial begin
    int unsigned pc;
    int unsigned pr;
    int unsigned run_len;
    int unsigned n;
    int unsigned random_sent;
    int unsigned phase;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_register(hcfda_pkg::REG_PIXEL_COUNT, hcfda_pkg::APB_DW'(hcfda_pkg::PIX_CNT_RST));
    check_register(hcfda_pkg::REG_PAIR_COUNT, hcfda_pkg::APB_DW'(hcfda_pkg::PAIR_CNT_RST));

    // partial frame with the reset settings
    apply_flow(FLOW_FREE);
    repeat (20) send_pixel(rand_pixel());

    // zero counts act as one
    start_run(0, 0);
    send_pixel('1); send_pixel('0);
    send_pixel('0); send_pixel('1);
    send_pixel('1); send_pixel('1);
    send_pixel('0); send_pixel('0);
    send_pixel(16'h5555); send_pixel(16'hAAAA);

    // oversized counts, partial frame only
    start_run(17'h1FFFF, 11'h7FF);
    repeat (12) send_pixel(rand_pixel());

    // restart in the middle of a run
    start_run(2, 1);
    repeat (3) send_pixel(rand_pixel());
    start_run(2, 1);
    repeat (4) send_pixel(rand_pixel());

    start_run(2, 2);
    repeat (8) send_pixel(rand_pixel());

    // positive sum of full-scale pixels
    start_run(1, 16);
    repeat (16) begin
      send_pixel('1);
      send_pixel('0);
    end

    // negative sum of full-scale pixels on pixel 0, random data on pixel 1
    start_run(2, 16);
    repeat (16) begin
      send_pixel('0);
      send_pixel(rand_pixel());
      send_pixel('1);
      send_pixel(rand_pixel());
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       pc = 0;
        1:       pc = $urandom_range(17, 24);
        default: pc = $urandom_range(1, 12);
      endcase
      case ($urandom_range(9))
        0:       pr = 0;
        1:       pr = $urandom_range(4, 6);
        default: pr = $urandom_range(1, 3);
      endcase
      start_run(pc, pr);
      apply_flow(flow_mode_t'(phase % 4));
      run_len = 2 * pixel_sum_tracker::bounded(pc, MAX_PIXELS)
                  * pixel_sum_tracker::bounded(pr, MAX_PAIRS);
      n = run_len * $urandom_range(1, 2);
      // broken tail, cut short by the next restart
      if (run_len > 1 && $urandom_range(3) == 0) n += $urandom_range(1, run_len - 1);
      repeat (n) send_pixel(rand_pixel());
      random_sent += n;
      phase++;
    end

    drain();
    if (tracker.pending_sums.size() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived",
                                        tracker.pending_sums.size()));
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/hcfda_pkg.sv
hw/rtl/hcfda_ram.sv
hw/rtl/hot_cold_frame_difference_accumulator.sv
hw/rtl/hcfda_chk.sv
sim/tb_hot_cold_frame_difference_accumulator.sv
